[sv/taylor_sine_degree15_unit_macros.svh]
// Assertion macros shared by the Taylor sine unit.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef TAYLOR_SINE_DEGREE15_UNIT_MACROS_SVH
`define TAYLOR_SINE_DEGREE15_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define TSD_ASSERT_IMPL(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("tsd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TSD_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("tsd assertion failed");

`else

`define TSD_ASSERT_IMPL(name, ck, rs, ante, cons)
`define TSD_ASSERT_NEXT(name, ck, rs, ante, cons)

`endif

`endif

[sv/tsd_pkg.sv]
// Package for the Taylor sine unit: fixed-point widths, constants and the
// operand bundle carried down the pipeline. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsd_pkg;

  localparam int ANGLE_W    = 31;
  localparam int SINE_W     = 32;
  localparam int XM_W       = 30;
  localparam int SQ_W       = 2 * XM_W;
  localparam int X2_W       = 32;
  localparam int ACC_W      = 32;
  localparam int AM_W       = 31;
  localparam int P_W        = AM_W + X2_W;
  localparam int FRAC_SHIFT = 28;
  localparam int HALF_SHIFT = FRAC_SHIFT - 1;
  localparam int U_W        = 35;
  localparam int U_LO_W     = 18;
  localparam int U_HI_W     = U_W - U_LO_W;
  localparam int RECIP_W    = 33;
  localparam int RECIP_SHIFT = U_W;
  localparam int PH_W       = U_HI_W + RECIP_W;
  localparam int PL_W       = U_LO_W + RECIP_W;
  localparam int QS_W       = U_W + RECIP_W;
  localparam int Q_W        = 33;
  localparam int D_W        = 9;
  localparam int PROD_W     = XM_W + AM_W;
  localparam int RM_W       = PROD_W - FRAC_SHIFT;

  localparam int TERM_COUNT_DEF = 8;

  localparam logic signed [ANGLE_W-1:0] PI_Q28     = 31'sd843314857;
  localparam logic signed [ANGLE_W-1:0] NEG_PI_Q28 = -31'sd843314857;
  localparam logic [ACC_W-1:0]          ONE_Q30    = 32'd1073741824;
  localparam logic signed [SINE_W-1:0]  SINE_MAX   = 32'sd1073741824;
  localparam logic signed [SINE_W-1:0]  SINE_MIN   = -32'sd1073741824;

  // Operands that every term stage needs besides the running accumulator.
  typedef struct packed {
    logic [XM_W-1:0] xm;
    logic            xneg;
    logic [X2_W-1:0] x2;
  } carry_t;

endpackage

`default_nettype wire

[sv/taylor_sine_degree15_unit.sv]
// Taylor sine unit: top level with the angle front end, the chain of Horner
// term stages and the output scaling. Uses tsd_pkg, tsd_term and the macros header.
//
// Usage:
//   Input channel: angle (signed Q2.28 radians) with angle_valid / angle_stall.
//   A transaction takes place at a rising edge with angle_valid high and
//   angle_stall low. Angles beyond plus or minus pi are clamped to the limit.
//   Output channel: sine_value (signed Q1.30) with sine_valid / sine_stall,
//   saturated to plus or minus one.
//   Throughput: one angle per clock cycle, sustained while the receiver does not stall.
//   Pipeline: three front-end stages, four stages per Horner term, one
//   scaling stage and the output register.
//   Each stage has its own valid bit and loads whenever it is empty or its
//   contents move on, so bubbles are squeezed out. When the receiver stalls,
//   the result holds in the output register and new angles are still taken
//   until every stage is full; only then is angle_stall raised.
//   Reset (rst, synchronous) empties all stages; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "taylor_sine_degree15_unit_macros.svh"

module taylor_sine_degree15_unit #(
  parameter int TERM_COUNT = tsd_pkg::TERM_COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic signed [tsd_pkg::ANGLE_W-1:0]  angle,
  input  wire logic                                angle_valid,
  output logic                                     angle_stall,
  output logic signed [tsd_pkg::SINE_W-1:0]        sine_value,
  output logic                                     sine_valid,
  input  wire logic                                sine_stall
);
  import tsd_pkg::*;

  localparam int STAGES = TERM_COUNT - 1;

  logic f0v, f1v, f2v, gv;
  logic go0, go1, go2, go_g, go_o;

  logic [XM_W-1:0]  f0_xm;
  logic             f0_xneg;
  logic [SQ_W-1:0]  f1_sq;
  logic [XM_W-1:0]  f1_xm;
  logic             f1_xneg;
  carry_t           f2_carry;
  logic [PROD_W-1:0] g_prod;
  logic             g_sign;

  logic signed [ANGLE_W-1:0] xc;
  logic [ANGLE_W-1:0]        xabs;
  logic [SQ_W-1:0]           sq_sum;
  logic [ACC_W-1:0]          fin_abs;
  logic [AM_W-1:0]           fin_am;
  logic [PROD_W-1:0]         r_sum;
  logic [RM_W-1:0]           rm;
  logic [SINE_W-1:0]         rm_sat;

  logic                    tv     [0:STAGES];
  logic                    tstall [0:STAGES];
  logic signed [ACC_W-1:0] tacc   [0:STAGES];
  carry_t                  tcarry [0:STAGES];

  // Stall chain, from the output register back to the input.
  assign go_o = ~sine_valid | ~sine_stall;
  assign go_g = ~gv | go_o;
  assign tstall[STAGES] = ~go_g;
  assign go2  = ~f2v | ~tstall[0];
  assign go1  = ~f1v | go2;
  assign go0  = ~f0v | go1;
  assign angle_stall = ~go0;

  // Front end: clamp and take the magnitude, square, round to Q28.
  always_comb begin
    if (angle > PI_Q28) begin
      xc = PI_Q28;
    end else if (angle < NEG_PI_Q28) begin
      xc = NEG_PI_Q28;
    end else begin
      xc = angle;
    end
  end
  assign xabs   = xc[ANGLE_W-1] ? ANGLE_W'(-xc) : ANGLE_W'(xc);
  assign sq_sum = f1_sq + (SQ_W'(1) << HALF_SHIFT);

  assign tv[0]     = f2v;
  assign tacc[0]   = signed'(ONE_Q30);
  assign tcarry[0] = f2_carry;

  for (genvar j = 0; j < STAGES; j++) begin : g_term
    tsd_term #(
      .K(TERM_COUNT - 2 - j)
    ) u_term (
      .clk        (clk),
      .rst        (rst),
      .acc_valid  (tv[j]),
      .acc_stall  (tstall[j]),
      .acc        (tacc[j]),
      .carry      (tcarry[j]),
      .next_valid (tv[j+1]),
      .next_stall (tstall[j+1]),
      .next_acc   (tacc[j+1]),
      .next_carry (tcarry[j+1])
    );
  end

  // Back end: scale the polynomial by |x|, round, saturate and restore the sign.
  assign fin_abs = tacc[STAGES][ACC_W-1] ? ACC_W'(-tacc[STAGES]) : ACC_W'(tacc[STAGES]);
  assign fin_am  = fin_abs[AM_W-1:0];
  assign r_sum   = g_prod + (PROD_W'(1) << HALF_SHIFT);
  assign rm      = r_sum[FRAC_SHIFT +: RM_W];
  assign rm_sat  = (rm > RM_W'(ONE_Q30)) ? ONE_Q30 : SINE_W'(rm);

  always_ff @(posedge clk) begin
    if (rst) begin
      f0v        <= 1'b0;
      f1v        <= 1'b0;
      f2v        <= 1'b0;
      gv         <= 1'b0;
      sine_valid <= 1'b0;
    end else begin
      if (go0) begin
        f0v <= angle_valid;
      end
      if (go1) begin
        f1v <= f0v;
      end
      if (go2) begin
        f2v <= f1v;
      end
      if (go_g) begin
        gv <= tv[STAGES];
      end
      if (go_o) begin
        sine_valid <= gv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go0) begin
      f0_xm   <= xabs[XM_W-1:0];
      f0_xneg <= xc[ANGLE_W-1];
    end
    if (go1) begin
      f1_sq   <= SQ_W'(f0_xm) * SQ_W'(f0_xm);
      f1_xm   <= f0_xm;
      f1_xneg <= f0_xneg;
    end
    if (go2) begin
      f2_carry.xm   <= f1_xm;
      f2_carry.xneg <= f1_xneg;
      f2_carry.x2   <= sq_sum[FRAC_SHIFT +: X2_W];
    end
    if (go_g) begin
      g_prod <= PROD_W'(tcarry[STAGES].xm) * PROD_W'(fin_am);
      g_sign <= tcarry[STAGES].xneg ^ tacc[STAGES][ACC_W-1];
    end
    if (go_o) begin
      sine_value <= g_sign ? signed'(-rm_sat) : signed'(rm_sat);
    end
  end

  // Back-pressure at the input can only come from a full, stalled output.
  `TSD_ASSERT_IMPL(a_stall_source, clk, rst, angle_stall, sine_valid && sine_stall)
  // Every delivered result lies within plus or minus one.
  `TSD_ASSERT_IMPL(a_result_range, clk, rst, sine_valid, (sine_value <= SINE_MAX) && (sine_value >= SINE_MIN))
  // A zero product must leave as zero, never as a negated zero pattern.
  `TSD_ASSERT_NEXT(a_zero_result, clk, rst, gv && go_o && (g_prod == '0), sine_value == '0)

endmodule

`default_nettype wire

[sv/tsd_term.sv]
// One Horner step of the Taylor sine: acc' = 1 - sign(acc) * round(|acc| * x^2 / d).
// Four register stages; uses tsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsd_term #(
  parameter int K = 0
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              acc_valid,
  output logic                                   acc_stall,
  input  wire logic signed [tsd_pkg::ACC_W-1:0]  acc,
  input  wire tsd_pkg::carry_t                   carry,
  output logic                                   next_valid,
  input  wire logic                              next_stall,
  output logic signed [tsd_pkg::ACC_W-1:0]       next_acc,
  output tsd_pkg::carry_t                        next_carry
);
  import tsd_pkg::*;

  localparam int DIV = (2 * K + 2) * (2 * K + 3);
  localparam logic [D_W-1:0] DIV_C = D_W'(DIV);
  localparam longint RECIP_L = (longint'(1) << RECIP_SHIFT) / DIV;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam logic [P_W-1:0] ROUND = P_W'(DIV) << HALF_SHIFT;

  logic va, vb, vc, vd;
  logic go_a, go_b, go_c, go_d;

  logic [P_W-1:0]     a_p;
  logic               a_aneg;
  carry_t             a_carry;
  logic [U_W-1:0]     b_u;
  logic [PH_W-1:0]    b_ph;
  logic [PL_W-1:0]    b_pl;
  logic               b_aneg;
  carry_t             b_carry;
  logic [Q_W-1:0]     c_qe;
  logic [U_W-1:0]     c_u;
  logic               c_aneg;
  carry_t             c_carry;
  logic signed [ACC_W-1:0] d_acc;
  carry_t             d_carry;

  logic [ACC_W-1:0]   acc_abs;
  logic [AM_W-1:0]    am;
  logic [P_W-1:0]     a_p_next;
  logic [P_W-1:0]     u_sum;
  logic [U_W-1:0]     u;
  logic [PH_W-1:0]    ph_next;
  logic [PL_W-1:0]    pl_next;
  logic [QS_W-1:0]    qs;
  logic [Q_W+D_W-1:0] qd_full;
  logic [U_W-1:0]     rem;
  logic [Q_W-1:0]     q;
  logic [ACC_W-1:0]   q32;
  logic signed [ACC_W-1:0] acc_next;

  // A stage may load when it is empty or its contents move on.
  assign go_d = ~vd | ~next_stall;
  assign go_c = ~vc | go_d;
  assign go_b = ~vb | go_c;
  assign go_a = ~va | go_b;
  assign acc_stall = ~go_a;

  // Stage A: magnitude of the accumulator times x squared.
  assign acc_abs  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign am       = acc_abs[AM_W-1:0];
  assign a_p_next = P_W'(am) * P_W'(carry.x2);

  // Stage B: round to a Q30 numerator, then multiply by the reciprocal of d
  // in two partial products.
  assign u_sum   = a_p + ROUND;
  assign u       = u_sum[FRAC_SHIFT +: U_W];
  assign ph_next = PH_W'(u[U_W-1:U_LO_W]) * PH_W'(RECIP);
  assign pl_next = PL_W'(u[U_LO_W-1:0]) * PL_W'(RECIP);

  // Stage C: the quotient estimate is exact or one short.
  assign qs = (QS_W'(b_ph) << U_LO_W) + QS_W'(b_pl);

  // Stage D: correct the estimate and fold it into the next accumulator.
  assign qd_full  = (Q_W+D_W)'(c_qe) * (Q_W+D_W)'(DIV_C);
  assign rem      = c_u - qd_full[U_W-1:0];
  assign q        = c_qe + Q_W'(rem >= U_W'(DIV_C));
  assign q32      = q[ACC_W-1:0];
  assign acc_next = c_aneg ? signed'(ONE_Q30 + q32) : signed'(ONE_Q30 - q32);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      if (go_a) begin
        va <= acc_valid;
      end
      if (go_b) begin
        vb <= va;
      end
      if (go_c) begin
        vc <= vb;
      end
      if (go_d) begin
        vd <= vc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go_a) begin
      a_p     <= a_p_next;
      a_aneg  <= acc[ACC_W-1];
      a_carry <= carry;
    end
    if (go_b) begin
      b_u     <= u;
      b_ph    <= ph_next;
      b_pl    <= pl_next;
      b_aneg  <= a_aneg;
      b_carry <= a_carry;
    end
    if (go_c) begin
      c_qe    <= qs[RECIP_SHIFT +: Q_W];
      c_u     <= b_u;
      c_aneg  <= b_aneg;
      c_carry <= b_carry;
    end
    if (go_d) begin
      d_acc   <= acc_next;
      d_carry <= c_carry;
    end
  end

  assign next_valid = vd;
  assign next_acc   = d_acc;
  assign next_carry = d_carry;

endmodule

`default_nettype wire

[sim/tb_taylor_sine_degree15_unit.sv]
// Self-checking testbench for taylor_sine_degree15_unit: directed and random angles,
// checked against a bit-exact fixed-point sine predictor with random idling on both sides.
// Depends on tsd_pkg and the taylor_sine_degree15_unit RTL.
`timescale 1ns / 1ps

module tb_taylor_sine_degree15_unit;
  import tsd_pkg::*;

  localparam int TERMS         = TERM_COUNT_DEF;
  localparam int PIPE_LATENCY  = 4 * TERMS;
  localparam int RANDOM_ANGLES = 1600;
  localparam int MAX_WAIT      = 10;
  localparam int QUIET_LIMIT   = 2000;
  localparam int HALF_PI_Q28   = 421657428;
  localparam int DIRECTED_COUNT = 24;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      fixed_sine;
    logic signed [SINE_W-1:0]  sine;
  } sine_vector_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [SINE_W-1:0]  sine;
  } sine_expect_t;

  // Rows with fixed_sine set carry a result that follows directly from the
  // rounding: tiny angles give x scaled by four, since x squared rounds to zero.
  localparam sine_vector_t DIRECTED_TABLE [0:DIRECTED_COUNT-1] = '{
    '{31'sd0, 1'b1, 32'sd0},
    '{31'sd1, 1'b1, 32'sd4},
    '{-31'sd1, 1'b1, -32'sd4},
    '{31'sd2, 1'b1, 32'sd8},
    '{-31'sd2, 1'b1, -32'sd8},
    '{PI_Q28, 1'b0, 32'sd0},
    '{NEG_PI_Q28, 1'b0, 32'sd0},
    '{PI_Q28 + 31'sd1, 1'b0, 32'sd0},
    '{NEG_PI_Q28 - 31'sd1, 1'b0, 32'sd0},
    '{31'h3FFF_FFFF, 1'b0, 32'sd0},
    '{31'h4000_0000, 1'b0, 32'sd0},
    '{31'sd421657428, 1'b0, 32'sd0},
    '{-31'sd421657428, 1'b0, 32'sd0},
    '{31'sd421657429, 1'b0, 32'sd0},
    '{31'sd421657427, 1'b0, 32'sd0},
    '{31'sd421661524, 1'b0, 32'sd0},
    '{-31'sd421661524, 1'b0, 32'sd0},
    '{31'sd268435456, 1'b0, 32'sd0},
    '{-31'sd268435456, 1'b0, 32'sd0},
    '{31'sd140552476, 1'b0, 32'sd0},
    '{-31'sd140552476, 1'b0, 32'sd0},
    '{31'sd632486143, 1'b0, 32'sd0},
    '{31'h2AAA_AAAA, 1'b0, 32'sd0},
    '{31'h5555_5555, 1'b0, 32'sd0}
  };

  logic                      clk;
  logic                      rst;
  logic signed [ANGLE_W-1:0] angle;
  logic                      angle_valid;
  logic                      angle_stall;
  logic signed [SINE_W-1:0]  sine_value;
  logic                      sine_valid;
  logic                      sine_stall;

  sine_expect_t sines_pending [$];
  sine_expect_t oldest_sine;
  int           failures = 0;
  int           quiet_cycles = 0;
  bit           send_burst = 1'b0;
  bit           recv_burst = 1'b0;

  taylor_sine_degree15_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .angle       (angle),
    .angle_valid (angle_valid),
    .angle_stall (angle_stall),
    .sine_value  (sine_value),
    .sine_valid  (sine_valid),
    .sine_stall  (sine_stall)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Clamp to plus or minus pi, nested evaluation in x squared, then scale by x.
  function automatic logic signed [SINE_W-1:0] sine_of_angle(
    input logic signed [ANGLE_W-1:0] angle_in
  );
    longint                   x;
    longint                   acc;
    longint unsigned          xm, x2, am, div, q, rm;
    bit                       x_neg, acc_neg;
    logic signed [SINE_W-1:0] sine;
    x = angle_in;
    if (x > longint'(PI_Q28)) x = longint'(PI_Q28);
    if (x < longint'(NEG_PI_Q28)) x = longint'(NEG_PI_Q28);
    x_neg = x < 0;
    xm = x_neg ? -x : x;
    x2 = (xm * xm + (64'd1 << HALF_SHIFT)) >> FRAC_SHIFT;
    acc = longint'(ONE_Q30);
    for (int k = TERMS - 2; k >= 0; k--) begin
      div = (2 * k + 2) * (2 * k + 3);
      acc_neg = acc < 0;
      am = acc_neg ? -acc : acc;
      q = (am * x2 + (div << HALF_SHIFT)) / (div << FRAC_SHIFT);
      acc = acc_neg ? longint'(ONE_Q30) + longint'(q) : longint'(ONE_Q30) - longint'(q);
    end
    acc_neg = acc < 0;
    am = acc_neg ? -acc : acc;
    rm = (xm * am + (64'd1 << HALF_SHIFT)) >> FRAC_SHIFT;
    if (rm > longint'(ONE_Q30)) rm = longint'(ONE_Q30);
    sine = rm[SINE_W-1:0];
    return (x_neg != acc_neg) ? -sine : sine;
  endfunction

  // Mostly legal angles, with the clamp edges, the peak near pi/2, tiny
  // magnitudes and raw 31-bit patterns mixed in.
  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int pick;
    int offset;
    int pi_int;
    pi_int = int'(PI_Q28);
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        return ANGLE_W'($urandom());
      end
      1: begin
        offset = int'($urandom_range(0, 128)) - 64;
        return ANGLE_W'(($urandom_range(0, 1) ? pi_int : -pi_int) + offset);
      end
      2: begin
        offset = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        return ANGLE_W'(($urandom_range(0, 1) ? HALF_PI_Q28 : -HALF_PI_Q28) + offset);
      end
      3: begin
        return ANGLE_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
      end
      default: begin
        return ANGLE_W'(int'($urandom_range(0, 2 * pi_int)) - pi_int);
      end
    endcase
  endfunction

  task automatic flag_failure(input string what);
    failures++;
    if (failures <= 10) $display("%s", what);
  endtask

  // Called and returning at a falling edge; valid stays high when the next
  // transaction follows with no gap.
  task automatic send_angle(
    input logic signed [ANGLE_W-1:0] angle_in,
    input logic signed [SINE_W-1:0]  sine_exp
  );
    int gap;
    if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      angle_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    angle = angle_in;
    angle_valid = 1'b1;
    do @(posedge clk); while (angle_stall);
    sines_pending.push_back('{angle_in, sine_exp});
    @(negedge clk);
  endtask

  initial begin
    logic signed [ANGLE_W-1:0] next_angle;
    rst = 1'b1;
    angle = '0;
    angle_valid = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_angle(DIRECTED_TABLE[i].angle,
                 DIRECTED_TABLE[i].fixed_sine ? DIRECTED_TABLE[i].sine
                                              : sine_of_angle(DIRECTED_TABLE[i].angle));
    end
    for (int i = 0; i < RANDOM_ANGLES; i++) begin
      next_angle = random_angle();
      send_angle(next_angle, sine_of_angle(next_angle));
    end
    angle_valid = 1'b0;
    while (sines_pending.size() != 0) @(posedge clk);
    // Catch any extra result that trails the last expected one.
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (failures == 0) begin
      $display("taylor_sine_degree15_unit regression: pass");
    end else begin
      $display("taylor_sine_degree15_unit regression: fail");
    end
    $finish;
  end

  // Result side: stall a random number of cycles ahead of each transaction.
  initial begin
    int hold;
    sine_stall = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) recv_burst = !recv_burst;
      hold = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (hold > 0) begin
        sine_stall = 1'b1;
        repeat (hold) @(negedge clk);
        sine_stall = 1'b0;
      end
      do @(posedge clk); while (sine_valid !== 1'b1);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (sine_valid && !sine_stall) begin
        if (sines_pending.size() == 0) begin
          flag_failure($sformatf("unexpected sine transaction: got %0d", sine_value));
        end else begin
          oldest_sine = sines_pending.pop_front();
          if (sine_value !== oldest_sine.sine) begin
            flag_failure($sformatf("sine mismatch: angle %0d expected %0d got %0d",
                                   oldest_sine.angle, oldest_sine.sine, sine_value));
          end
        end
      end
      if ((angle_valid && !angle_stall) || (sine_valid && !sine_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("taylor_sine_degree15_unit regression: fail");
        $finish;
      end
    end
  end

endmodule
